@@ rtl/core/tick_timer_bank_unit_macros.svh @@
// Assertion macros shared by the timer bank checker.
// No dependencies.
`ifndef TICK_TIMER_BANK_UNIT_MACROS_SVH
`define TICK_TIMER_BANK_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define TTB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define TTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/ttb_pkg.sv @@
// Package for the timer bank: sizes, operation, mode and reply codes, item types.
// No dependencies.
`default_nettype none
package ttb_pkg;
  localparam int SlotCount = 16;
  localparam int SlotBits = $clog2(SlotCount);
  localparam int CountBits = $clog2(SlotCount + 1);
  localparam int ExpireBatch = 4;
  localparam int BatchBits = $clog2(ExpireBatch + 1);
  localparam logic [15:0] FirstIdent = 16'h6000;

  localparam logic [2:0] OpCreate  = 3'd0;
  localparam logic [2:0] OpDestroy = 3'd1;
  localparam logic [2:0] OpStart   = 3'd2;
  localparam logic [2:0] OpCancel  = 3'd3;
  localparam logic [2:0] OpTick    = 3'd4;

  localparam logic [1:0] ModeOff    = 2'd0;
  localparam logic [1:0] ModeOnce   = 2'd1;
  localparam logic [1:0] ModeReload = 2'd2;

  localparam logic KindReply  = 1'b0;
  localparam logic KindExpiry = 1'b1;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] timer_id;
    logic [31:0] period_ticks;
    logic [1:0]  reload_mode;
    logic [31:0] now_ticks;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic        status;
    logic [15:0] result_id;
    logic        last;
  } rsp_t;
endpackage
`default_nettype wire

@@ rtl/core/ttb_if.sv @@
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is given by the user.
`default_nettype none
interface ttb_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tick_timer_bank_unit.sv @@
// Timer bank: one command or tick at a time, run by a sequencer over slots.
// Each scan of slots or of the running list steps through it one entry at a time; the
// compare unit serves the running-list insertion scan. A tick walks the list once per
// expired timer and once per re-insert. The input is not ready while busy, so a new
// item is taken only once the last one is through and its result has been accepted.
// Synchronous reset clears slot use, modes, the list count and the ID counter.
`default_nettype none
module tick_timer_bank_unit (
  input  wire logic clk,
  input  wire logic rst,
  ttb_if.sink       in_ch,
  ttb_if.source     out_ch
);
  localparam int SB = ttb_pkg::SlotBits;
  localparam int CB = ttb_pkg::CountBits;
  localparam int N  = ttb_pkg::SlotCount;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIND  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_RMSCN = 4'd3;
  localparam logic [3:0] S_RMSH  = 4'd4;
  localparam logic [3:0] S_INSCN = 4'd5;
  localparam logic [3:0] S_INSSH = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_POPSH = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_RELD  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_AFTRM = 4'd12;

  logic [3:0] state;
  ttb_pkg::cmd_t cmd;
  logic [N-1:0] used;
  logic [1:0] mode [N];
  logic [15:0] ident [N];
  logic [31:0] period [N];
  logic [31:0] deadline [N];
  logic [SB-1:0] order [N];
  logic [CB-1:0] count;
  logic [15:0] next_ident;
  logic [CB-1:0] idx;
  logic [SB-1:0] slot;
  logic found;
  logic [SB-1:0] popped [ttb_pkg::ExpireBatch];
  logic [ttb_pkg::BatchBits-1:0] npop;
  logic [ttb_pkg::BatchBits-1:0] emit;
  ttb_pkg::rsp_t rsp;
  logic out_valid;

  // Shared compare unit: list entry deadline against a key.
  logic [31:0] key;
  logic [31:0] cmp_dl;
  logic cmp_le;
  always_comb begin
    cmp_dl = deadline[order[idx[SB-1:0]]];
    cmp_le = cmp_dl <= key;
  end

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      count <= '0;
      next_ident <= ttb_pkg::FirstIdent;
      out_valid <= 1'b0;
      for (int i = 0; i < N; i++) mode[i] <= ttb_pkg::ModeOff;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cmd <= in_ch.data;
            idx <= '0;
            found <= 1'b0;
            state <= S_FIND;
          end
        end
        // Slot scan: free slot for create, matching ID otherwise.
        S_FIND: begin
          if (idx == CB'(N)) begin
            state <= S_DISP;
          end else begin
            if (!found && ((cmd.operation == ttb_pkg::OpCreate) ? !used[idx[SB-1:0]]
                : (used[idx[SB-1:0]] && ident[idx[SB-1:0]] == cmd.timer_id))) begin
              found <= 1'b1;
              slot <= idx[SB-1:0];
            end
            idx <= idx + 1'b1;
          end
        end
        S_DISP: begin
          rsp <= '{kind: ttb_pkg::KindReply, status: ttb_pkg::StatusFail,
                   result_id: 16'd0, last: 1'b1};
          idx <= '0;
          state <= S_OUT;
          case (cmd.operation)
            ttb_pkg::OpCreate: begin
              if (cmd.period_ticks != 0 && found) begin
                used[slot] <= 1'b1;
                ident[slot] <= next_ident;
                period[slot] <= cmd.period_ticks;
                deadline[slot] <= '0;
                mode[slot] <= ttb_pkg::ModeOff;
                next_ident <= next_ident + 16'd1;
                rsp <= '{kind: ttb_pkg::KindReply, status: ttb_pkg::StatusOk,
                         result_id: next_ident, last: 1'b1};
              end
            end
            ttb_pkg::OpDestroy, ttb_pkg::OpCancel, ttb_pkg::OpStart: begin
              if (found && !(cmd.operation == ttb_pkg::OpStart && cmd.reload_mode > 2'd1)
                  && !(cmd.operation == ttb_pkg::OpCancel
                       && mode[slot] == ttb_pkg::ModeOff)) begin
                rsp.status <= ttb_pkg::StatusOk;
                state <= (mode[slot] != ttb_pkg::ModeOff) ? S_RMSCN : S_AFTRM;
              end
            end
            ttb_pkg::OpTick: begin
              npop <= '0;
              state <= S_POP;
              key <= cmd.now_ticks;
            end
            default: ;
          endcase
        end
        // Find the slot in the running list.
        S_RMSCN: begin
          if (idx >= count) state <= S_AFTRM;
          else if (order[idx[SB-1:0]] == slot) state <= S_RMSH;
          else idx <= idx + 1'b1;
        end
        // Close the gap one entry per cycle.
        S_RMSH: begin
          if (idx + 1'b1 < count) begin
            order[idx[SB-1:0]] <= order[SB'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end else begin
            count <= count - 1'b1;
            state <= S_AFTRM;
          end
        end
        S_AFTRM: begin
          state <= S_OUT;
          if (cmd.operation == ttb_pkg::OpStart) begin
            mode[slot] <= cmd.reload_mode[0] ? ttb_pkg::ModeReload : ttb_pkg::ModeOnce;
            deadline[slot] <= cmd.now_ticks + period[slot];
            key <= cmd.now_ticks + period[slot];
            idx <= '0;
            state <= S_INSCN;
          end else begin
            mode[slot] <= ttb_pkg::ModeOff;
            if (cmd.operation == ttb_pkg::OpDestroy) used[slot] <= 1'b0;
          end
        end
        // Insertion point: after every entry with deadline not after key.
        S_INSCN: begin
          if (count >= CB'(N)) state <= (cmd.operation == ttb_pkg::OpTick) ? S_RELD : S_OUT;
          else if (idx < count && cmp_le) idx <= idx + 1'b1;
          else begin
            key[CB-1:0] <= count;
            state <= S_INSSH;
          end
        end
        // Shift entries up from the tail, key low bits hold the walk position.
        S_INSSH: begin
          if (key[CB-1:0] > idx) begin
            order[key[SB-1:0]] <= order[SB'(key[CB-1:0] - 1'b1)];
            key[CB-1:0] <= key[CB-1:0] - 1'b1;
          end else begin
            order[idx[SB-1:0]] <= slot;
            count <= count + 1'b1;
            state <= (cmd.operation == ttb_pkg::OpTick) ? S_RELD : S_OUT;
          end
        end
        // Pop expired heads.
        S_POP: begin
          if (count != 0 && npop != ttb_pkg::BatchBits'(ttb_pkg::ExpireBatch)
              && cmd.now_ticks >= deadline[order[0]]) begin
            popped[npop[$clog2(ttb_pkg::ExpireBatch)-1:0]] <= order[0];
            npop <= npop + 1'b1;
            idx <= '0;
            state <= S_POPSH;
          end else begin
            emit <= '0;
            state <= (npop == 0) ? S_IDLE : S_EMIT;
          end
        end
        S_POPSH: begin
          if (idx + 1'b1 < count) begin
            order[idx[SB-1:0]] <= order[SB'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end else begin
            count <= count - 1'b1;
            state <= S_POP;
          end
        end
        // Report one popped timer, then reload or disable it.
        S_EMIT: begin
          if (!out_valid) begin
            slot <= popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]];
            rsp <= '{kind: ttb_pkg::KindExpiry, status: ttb_pkg::StatusOk,
                     result_id: ident[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]],
                     last: (emit + 1'b1 == npop)};
            out_valid <= 1'b1;
            emit <= emit + 1'b1;
            if (mode[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]]
                == ttb_pkg::ModeReload) begin
              deadline[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]] <=
                deadline[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]]
                + period[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]];
              key <= deadline[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]]
                + period[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]];
              idx <= '0;
              state <= S_INSCN;
            end else begin
              mode[popped[emit[$clog2(ttb_pkg::ExpireBatch)-1:0]]] <= ttb_pkg::ModeOff;
              state <= S_RELD;
            end
          end
        end
        S_RELD: begin
          state <= (emit == npop) ? S_IDLE : S_EMIT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ttb_checker.sv @@
// Port checker for the timer bank, bound to tick_timer_bank_unit.
// Depends on ttb_pkg, ttb_if and the assertion macro header.
`default_nettype none
`include "tick_timer_bank_unit_macros.svh"
module ttb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire ttb_pkg::rsp_t out_data
);
  // A stalled result holds.
  `TTB_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // Expiry events never carry a fail status.
  `TTB_ASSERT_IMP(a_evt_ok, clk, rst, out_valid && out_data.kind, !out_data.status)
  // Command replies always end their item.
  `TTB_ASSERT_IMP(a_cmd_last, clk, rst, out_valid && !out_data.kind, out_data.last)
  // No new input while a result is pending.
  `TTB_ASSERT_IMP(a_busy, clk, rst, out_valid, !in_ready)
  // After an input transfer the block is busy.
  `TTB_ASSERT_NEXT(a_take, clk, rst, in_valid && in_ready, !in_ready)
endmodule
bind tick_timer_bank_unit ttb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
